/* rtl/core/dsc_pkg.sv */
// Shared types and constants of the duplicate-suppression cache.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package dsc_pkg;

  localparam int ID_W   = 32;
  localparam int TTL_W  = 8;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic KIND_RECV  = 1'b0;
  localparam logic KIND_LOCAL = 1'b1;

  typedef enum logic [1:0] {
    RES_FWD     = 2'd0,
    RES_EXPIRED = 2'd1,
    RES_DUP     = 2'd2,
    RES_LOCAL   = 2'd3
  } res_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      write_hit;
    logic      write_ins;
    logic      emit;
    res_code_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic in_ttl_zero;
    logic hit;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/core/dsc_ctrl.sv */
// Controller of the duplicate-suppression cache: sequences accept, scan,
// write-back and result. Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  dsc_pkg::dp_stat_t  stat,
  output dsc_pkg::ctrl_cmd_t cmd
);

  dsc_pkg::state_t    state, state_next;
  dsc_pkg::res_code_t code, code_next;
  logic               accept;

  assign s_tready = (state == dsc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsc_pkg::ST_IDLE;
      code  <= dsc_pkg::RES_FWD;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dsc_pkg::ST_IDLE: begin
        if (accept) begin
          if (stat.in_kind == dsc_pkg::KIND_RECV && stat.in_ttl_zero) begin
            state_next = dsc_pkg::ST_EMIT;
          end else begin
            state_next = dsc_pkg::ST_SCAN;
          end
        end
      end
      dsc_pkg::ST_SCAN: begin
        if (stat.hit) begin
          state_next = dsc_pkg::ST_EMIT;
        end else if (stat.last) begin
          state_next = dsc_pkg::ST_WRITE;
        end
      end
      dsc_pkg::ST_WRITE: begin
        state_next = dsc_pkg::ST_EMIT;
      end
      dsc_pkg::ST_EMIT: begin
        if (!stat.out_busy) begin
          state_next = dsc_pkg::ST_IDLE;
        end
      end
      default: state_next = dsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.code  = code;
    code_next = code;
    unique case (state)
      dsc_pkg::ST_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          if (stat.in_kind == dsc_pkg::KIND_LOCAL) begin
            code_next = dsc_pkg::RES_LOCAL;
          end else if (stat.in_ttl_zero) begin
            code_next = dsc_pkg::RES_EXPIRED;
          end else begin
            code_next = dsc_pkg::RES_FWD;
          end
        end
      end
      dsc_pkg::ST_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.write_hit = stat.hit;
        if (stat.hit) begin
          code_next = dsc_pkg::RES_DUP;
        end
      end
      dsc_pkg::ST_WRITE: begin
        cmd.write_ins = 1'b1;
      end
      dsc_pkg::ST_EMIT: begin
        cmd.emit = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/dsc_datapath.sv */
// Datapath of the duplicate-suppression cache: item registers, entry memory,
// valid bits, scan pipeline with match and oldest-age search, result register.
// Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_datapath #(
  parameter int CACHE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dsc_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      s_tuser,
  input  logic [71:0]               s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,
  output logic [1:0]                m_tuser,
  input  dsc_pkg::ctrl_cmd_t        cmd,
  output dsc_pkg::dp_stat_t         stat
);

  localparam int IW  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW0 = $clog2(CACHE_DEPTH + 1);
  localparam int CW  = (CW0 > dsc_pkg::CFG_W) ? CW0 : dsc_pkg::CFG_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(CACHE_DEPTH);

  logic [dsc_pkg::CFG_W-1:0]  cfg_n;
  logic [CW-1:0]              cfg_ext, n_act, n_m1;

  logic                       kind_q;
  logic [dsc_pkg::ID_W-1:0]   id_q;
  logic [dsc_pkg::TTL_W-1:0]  ttl_q;
  logic [dsc_pkg::TIME_W-1:0] now_q;

  logic [dsc_pkg::ID_W-1:0]   ids  [CACHE_DEPTH];
  logic [dsc_pkg::TIME_W-1:0] ages [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0]     valid;

  logic [CW-1:0]              rd_ptr;
  logic                       issue;
  logic                       pend;
  logic [IW-1:0]              pend_idx;
  logic [dsc_pkg::ID_W-1:0]   id_rd;
  logic [dsc_pkg::TIME_W-1:0] age_rd;
  logic                       valid_rd;
  logic [dsc_pkg::TIME_W-1:0] age_eff;
  logic                       cmp_en, match;

  logic [IW-1:0]              best_idx;
  logic [dsc_pkg::TIME_W-1:0] best_age;

  logic                       out_valid;
  logic                       out_fwd;
  logic [dsc_pkg::TTL_W-1:0]  out_ttl;
  dsc_pkg::res_code_t         out_code;

  // Effective entry count: zero acts as one, large values clamp to the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_n <= dsc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_n <= cfg_wdata;
    end
  end

  assign cfg_ext = CW'(cfg_n);
  always_comb begin
    priority if (cfg_ext == '0) begin
      n_act = CW'(1);
    end else if (cfg_ext > DEPTH_C) begin
      n_act = DEPTH_C;
    end else begin
      n_act = cfg_ext;
    end
  end
  assign n_m1 = n_act - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= s_tuser;
      id_q   <= s_tdata[31:0];
      ttl_q  <= s_tdata[39:32];
      now_q  <= s_tdata[71:40];
    end
  end

  assign issue = cmd.scan && (rd_ptr < n_act);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      pend   <= 1'b0;
    end else if (cmd.load) begin
      rd_ptr <= '0;
      pend   <= 1'b0;
    end else if (cmd.scan) begin
      rd_ptr <= rd_ptr + CW'(issue);
      pend   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= rd_ptr[IW-1:0];
    id_rd    <= ids[rd_ptr[IW-1:0]];
    age_rd   <= ages[rd_ptr[IW-1:0]];
    valid_rd <= valid[rd_ptr[IW-1:0]];
  end

  // Entry memory writes: age refresh on a hit, full entry on an insert.
  always_ff @(posedge clk) begin
    if (cmd.write_hit) begin
      ages[pend_idx] <= now_q;
    end else if (cmd.write_ins) begin
      ids[best_idx]  <= id_q;
      ages[best_idx] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.write_ins) begin
      valid[best_idx] <= 1'b1;
    end
  end

  assign cmp_en  = cmd.scan && pend;
  assign age_eff = valid_rd ? age_rd : '0;
  assign match   = valid_rd && (id_rd == id_q) && (kind_q == dsc_pkg::KIND_RECV);

  // Oldest entry among those in use; strict compare keeps the lowest index.
  always_ff @(posedge clk) begin
    if (cmp_en && ((pend_idx == '0) || (age_eff < best_age))) begin
      best_idx <= pend_idx;
      best_age <= age_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_code <= cmd.code;
      out_fwd  <= (cmd.code == dsc_pkg::RES_FWD);
      out_ttl  <= (cmd.code == dsc_pkg::RES_FWD) ? (ttl_q - 8'd1) : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_ttl, out_fwd};
  assign m_tuser  = out_code;

  assign stat.in_kind     = s_tuser;
  assign stat.in_ttl_zero = (s_tdata[39:32] == '0);
  assign stat.hit         = cmp_en && match;
  assign stat.last        = cmp_en && (CW'(pend_idx) == n_m1);
  assign stat.out_busy    = out_valid && !m_tready;

endmodule

/* rtl/core/gossip_duplicate_suppression_cache.sv */
// Top level of the duplicate-suppression cache for flooded messages.
// Instantiates dsc_ctrl and dsc_datapath; depends on dsc_pkg.
`timescale 1ns / 1ps

// This block filters flooded messages against a cache of CACHE_DEPTH recently
// seen message identifiers. A received message (tuser 0) with a TTL of zero is
// reported as expired and leaves the cache alone. Otherwise the first
// entries_in_use entries are scanned: on a hit the entry's age is refreshed to
// the item's time tick and the message is reported as a duplicate; on a miss
// the entry with the smallest age (lowest index on ties, never-written entries
// counting as age zero) is replaced and the message is forwarded with its TTL
// reduced by one. A local message (tuser 1) only inserts, by the same rule.
// The block works on one item at a time and takes no new input until the
// result of the last one is loaded into the result register, which waits
// while an earlier result is still held. An expired message goes straight to
// the result; a hit ends the scan at the matching entry, and a miss or a local
// insert scans all effective entries before the write. The scan reads one
// memory address per cycle behind a registered read port. The input is ready
// again as soon as the result is loaded, even while that result waits to be
// taken. entries_in_use of zero acts as one, values above CACHE_DEPTH act as
// CACHE_DEPTH, and it should only be written while the block is idle.
module gossip_duplicate_suppression_cache #(
  parameter int CACHE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: entries_in_use.
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // msg_id[31:0], ttl_in[39:32], now[71:40]
  input  logic        s_tuser,   // kind[0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // forward[0], ttl_out[8:1], zero[15:9]
  output logic [1:0]  m_tuser    // status[1:0]
);

  dsc_pkg::ctrl_cmd_t cmd;
  dsc_pkg::dp_stat_t  stat;

  // The controller steps through accept, scan, write-back and result.
  dsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the item registers, the cache and the result register.
  dsc_datapath #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* tb/sv/tb_dedup_pkg.sv */
// Scoreboard for the duplicate-suppression cache testbench: a predictor of the
// message cache and the queue of verdicts it still owes. Depends on dsc_pkg.
`timescale 1ns / 1ps

package tb_dedup_pkg;

  import dsc_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic             fwd;
    logic [TTL_W-1:0] ttl;
    res_code_t        code;
  } verdict_t;

  class dedup_tracker;

    logic [ID_W-1:0]   slot_id [SLOTS];
    logic [TIME_W-1:0] slot_age [SLOTS];
    bit                slot_used [SLOTS];
    logic [CFG_W-1:0]  entries_reg;
    verdict_t          verdicts_due[$];
    int                errors;

    function new();
      foreach (slot_id[i]) begin
        slot_id[i]   = '0;
        slot_age[i]  = '0;
        slot_used[i] = 1'b0;
      end
      entries_reg = CFG_RESET;
      errors      = 0;
    endfunction

    function void set_entries(logic [CFG_W-1:0] value);
      entries_reg = value;
    endfunction

    // Zero behaves as one entry, anything past the cache size as the full cache.
    function int live_slots();
      if (entries_reg == 0)
        return 1;
      if (entries_reg > SLOTS)
        return SLOTS;
      return int'(entries_reg);
    endfunction

    // The oldest live entry is overwritten; the lowest index wins a tie.
    function void store_id(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
      int n;
      int victim;
      n      = live_slots();
      victim = 0;
      for (int i = 1; i < n; i++)
        if (slot_age[i] < slot_age[victim])
          victim = i;
      slot_id[victim]   = id;
      slot_age[victim]  = now;
      slot_used[victim] = 1'b1;
    endfunction

    function void note_message(logic kind, logic [ID_W-1:0] id, logic [TTL_W-1:0] ttl,
                               logic [TIME_W-1:0] now);
      verdict_t v;
      int       n;
      bit       hit;
      v.fwd  = 1'b0;
      v.ttl  = '0;
      v.code = RES_LOCAL;
      if (kind == KIND_LOCAL) begin
        store_id(id, now);
      end else if (ttl == 0) begin
        v.code = RES_EXPIRED;
      end else begin
        n   = live_slots();
        hit = 1'b0;
        for (int i = 0; i < n && !hit; i++)
          if (slot_used[i] && slot_id[i] == id) begin
            slot_age[i] = now;
            hit         = 1'b1;
          end
        if (hit) begin
          v.code = RES_DUP;
        end else begin
          store_id(id, now);
          v.fwd  = 1'b1;
          v.ttl  = ttl - 1'b1;
          v.code = RES_FWD;
        end
      end
      verdicts_due.push_back(v);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_verdict(logic fwd, logic [TTL_W-1:0] ttl, logic [1:0] code);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report("result transfer with no message outstanding");
        return;
      end
      want = verdicts_due.pop_front();
      if (fwd !== want.fwd)
        report($sformatf("forward %0b, expected %0b", fwd, want.fwd));
      if (ttl !== want.ttl)
        report($sformatf("ttl_out %0d, expected %0d", ttl, want.ttl));
      if (code !== want.code)
        report($sformatf("status %0d, expected %s", code, want.code.name()));
    endtask

    function int outstanding();
      return verdicts_due.size();
    endfunction

  endclass

endpackage

/* tb/sv/tb_top.sv */
// Top level of the duplicate-suppression cache testbench: clock, reset, stream
// drivers and the transfer monitor. Depends on dsc_pkg and tb_dedup_pkg.
`timescale 1ns / 1ps

module tb_top;

  import dsc_pkg::*;
  import tb_dedup_pkg::*;

  localparam int ITEMS_PER_PHASE = 42;
  localparam int PHASES          = 10;
  // The slowest legal run of all 434 messages, even with the longest gaps and
  // stalls, stays far below this limit.
  localparam int CYCLE_LIMIT     = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // msg_id[31:0], ttl_in[39:32], now[71:40]
  logic        s_tuser;   // kind[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // forward[0], ttl_out[8:1], zero[15:9]
  logic [1:0]  m_tuser;   // status[1:0]

  dedup_tracker tracker;
  int unsigned  cycle_count = 0;

  // Recently used identifiers are offered again so that duplicates, refreshes
  // and evictions all happen often.
  logic [31:0]  id_pool[$];
  logic [31:0]  tick;

  logic [4:0]   phase_entries [PHASES] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd3,
                                           5'd17, 5'd8, 5'd2, 5'd16, 5'd5};

  gossip_duplicate_suppression_cache dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Every transfer is observed at the rising edge. Inputs only move on the
  // falling edge, so the values seen here are settled. A result transfer is
  // checked before an input transfer on the same edge is noted; the result can
  // only belong to an earlier message.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we)
        tracker.set_entries(cfg_wdata);
      if (m_tvalid && m_tready)
        tracker.check_verdict(m_tdata[0], m_tdata[8:1], m_tuser);
      if (s_tvalid && s_tready)
        tracker.note_message(s_tuser, s_tdata[31:0], s_tdata[39:32], s_tdata[71:40]);
    end
  end

  // The result side stalls on its own pattern: long stretches of steady
  // readiness, stretches of random readiness, and hard stalls.
  initial begin
    int unsigned run_left;
    int unsigned mode;
    m_tready = 1'b0;
    run_left = 0;
    mode     = 0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      case (mode)
        0, 1: begin
          m_tready = 1'b1;
        end
        2: begin
          m_tready = ($urandom_range(0, 1) == 1);
        end
        default: begin
          m_tready = 1'b0;
        end
      endcase
    end
  end

  // Presents one message and holds it until its transfer. It returns on the
  // falling edge after the transfer with tvalid still high, so a message that
  // follows in the same burst keeps tvalid up without a dip.
  task automatic send_message(logic kind, logic [31:0] id, logic [7:0] ttl,
                              logic [31:0] now);
    s_tuser  = kind;
    s_tdata  = {now, ttl, id};
    s_tvalid = 1'b1;
    do
      @(posedge clk);
    while (!s_tready);
    @(negedge clk);
  endtask

  task automatic hold_off(int unsigned cycles);
    s_tvalid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits until every verdict owed by the block has been transferred. Every
  // message produces exactly one result, so the block is idle afterwards.
  task automatic drain();
    s_tvalid = 1'b0;
    while (tracker.outstanding() != 0)
      @(negedge clk);
  endtask

  task automatic write_entries(logic [4:0] value);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // A random message: mostly received ones, a good share with identifiers
  // seen before, some expired ones, and a clock that mostly creeps forward
  // (often by zero, so that ages tie) and sometimes jumps anywhere.
  task automatic send_random();
    logic        kind;
    logic [31:0] id;
    logic [7:0]  ttl;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    kind = (pick < 15) ? KIND_LOCAL : KIND_RECV;
    pick = $urandom_range(0, 99);
    if (id_pool.size() > 0 && pick < 55) begin
      id = id_pool[$urandom_range(0, id_pool.size() - 1)];
    end else begin
      id = $urandom;
      id_pool.push_back(id);
      if (id_pool.size() > 24)
        void'(id_pool.pop_front());
    end
    pick = $urandom_range(0, 99);
    if (pick < 8)
      ttl = 8'd0;
    else if (pick < 12)
      ttl = 8'd1;
    else
      ttl = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4)
      tick = $urandom;
    else
      tick = tick + $urandom_range(0, 3);
    send_message(kind, id, ttl, tick);
  endtask

  initial begin
    int sent;
    int burst;
    tracker   = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = KIND_RECV;
    tick      = 32'd100;
    id_pool.push_back(32'h0000_0000);
    id_pool.push_back(32'hFFFF_FFFF);
    id_pool.push_back(32'h1234_5678);
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed messages at the reset size of 16 entries.
    // Identifier zero must miss on the empty cache, then hit once stored.
    send_message(KIND_RECV, 32'h0000_0000, 8'd1, 32'd0);
    send_message(KIND_RECV, 32'h0000_0000, 8'd5, 32'd1);
    // Largest identifier, TTL and time; then an expired message for it, which
    // must leave the cache alone, and a duplicate that refreshes its age.
    send_message(KIND_RECV, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    send_message(KIND_RECV, 32'hFFFF_FFFF, 8'd0, 32'd2);
    send_message(KIND_RECV, 32'hFFFF_FFFF, 8'd1, 32'd3);
    // Local messages ignore the TTL and store a second copy of the same
    // identifier without a duplicate check.
    send_message(KIND_LOCAL, 32'h1234_5678, 8'hAA, 32'd4);
    send_message(KIND_LOCAL, 32'h1234_5678, 8'd0, 32'd5);
    send_message(KIND_RECV, 32'h1234_5678, 8'd2, 32'd6);
    // Ties at age zero on the untouched entries, then alternating bit patterns.
    send_message(KIND_RECV, 32'hA5A5_A5A5, 8'h80, 32'd0);
    send_message(KIND_RECV, 32'h5A5A_5A5A, 8'h7F, 32'h8000_0000);
    send_message(KIND_LOCAL, 32'h5A5A_5A5A, 8'hFF, 32'h0000_0000);
    send_message(KIND_RECV, 32'hA5A5_A5A5, 8'h55, 32'h7FFF_FFFF);
    send_message(KIND_RECV, 32'h0000_0001, 8'h2, 32'hFFFF_FFFE);
    send_message(KIND_RECV, 32'h0000_0000, 8'h0, 32'h0000_0000);

    // Random phases, each at its own entry count. The count is only changed
    // after the block has handed over every owed result, which also gives the
    // sender a full pause at the start of each phase.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_entries(phase_entries[p]);
      // One phase runs the clock through its wrap so that fresh entries look
      // older than stale ones.
      if (p == 5)
        tick = 32'hFFFF_FFF0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
          send_random();
          sent++;
        end
        // Some bursts run straight into the next one; the others stop for a
        // gap that can land anywhere in the block's scan.
        if ($urandom_range(0, 3) != 0)
          hold_off($urandom_range(1, 25));
      end
    end

    // Let the last results arrive, then watch a little longer for strays.
    drain();
    repeat (30) @(negedge clk);
    if (tracker.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* gossip_duplicate_suppression_cache.f */
rtl/core/dsc_pkg.sv
rtl/core/dsc_ctrl.sv
rtl/core/dsc_datapath.sv
rtl/core/gossip_duplicate_suppression_cache.sv
tb/sv/tb_dedup_pkg.sv
tb/sv/tb_top.sv
